// ===== hdl/interpolated_duty_window_check_unit_macros.svh =====
// Assertion macros used by the checker file.
`ifndef INTERPOLATED_DUTY_WINDOW_CHECK_UNIT_MACROS_SVH
`define INTERPOLATED_DUTY_WINDOW_CHECK_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define IDWC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define IDWC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/idwc_pkg.sv =====
// Types and constant stroke/limit table for the duty window check.
`timescale 1ns / 1ps
`default_nettype none

package idwc_pkg;

  localparam int TABLE_POINTS = 5;
  localparam int PT_W         = $clog2(TABLE_POINTS);
  localparam int STROKE_W     = 16;
  localparam int DUTY_W       = 14;
  localparam int TOL_W        = 11;
  localparam int SCL_W        = 33;

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(350);

  typedef logic [STROKE_W-1:0] stroke_t;
  typedef logic [DUTY_W-1:0]   duty_t;
  typedef logic [PT_W-1:0]     pt_idx_t;
  typedef logic signed [SCL_W-1:0] scaled_t;

  // Strokes in 0.01 mm, duties in 0.01 %.
  localparam stroke_t POS_TAB [TABLE_POINTS] = '{16'd0, 16'd200, 16'd400, 16'd600, 16'd800};
  localparam duty_t C1_LO_TAB [TABLE_POINTS] = '{14'd900, 14'd2090, 14'd3280, 14'd4480, 14'd5970};
  localparam duty_t C1_HI_TAB [TABLE_POINTS] = '{14'd1600, 14'd2790, 14'd3980, 14'd5180, 14'd6670};
  localparam duty_t C2_LO_TAB [TABLE_POINTS] = '{14'd8400, 14'd7220, 14'd6020, 14'd4820, 14'd3330};
  localparam duty_t C2_HI_TAB [TABLE_POINTS] = '{14'd9100, 14'd7920, 14'd6720, 14'd5520, 14'd4030};

endpackage

`default_nettype wire

// ===== hdl/interpolated_duty_window_check_unit.sv =====
// Interpolated duty window check: three-stage pipeline with output register.
//
// Input channel (in_valid/in_stall): stroke position plus two duty cycles.
// Result channel (out_valid/out_stall): passed, straight and swapped matches
// and an out-of-range flag, one result per input item, in order.
// Config channel (cfg_valid/cfg_ready): tolerance register, always ready;
// write it only while the pipeline is empty.
//
// The input transfer loads stage 1; the item then passes stages 2 and 3.
// One item per cycle is sustained while out_stall is low. Stage 1 finds the
// segment and applies the tolerance, stage 2 holds the eight multipliers
// (segment offset times limit slope, duty bound times segment length),
// stage 3 does the window compares into the output register.
//
// Reset clears all stage valid bits and loads the tolerance with 350.
// When the receiver stalls, the result holds; empty stages upstream still
// fill, and in_stall rises only once every stage holds an item.
`timescale 1ns / 1ps
`default_nettype none

module interpolated_duty_window_check_unit
  import idwc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [STROKE_W-1:0] in_stroke_value,
  input  wire logic [DUTY_W-1:0]   in_duty_a,
  input  wire logic [DUTY_W-1:0]   in_duty_b,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     out_passed,
  output logic                     out_straight_match,
  output logic                     out_swapped_match,
  output logic                     out_out_of_range,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [TOL_W-1:0]    cfg_tolerance
);

  logic [TOL_W-1:0] tol_r;

  logic v1_r, v2_r, v3_r;
  logic en1, en2, en3;

  // stage 1 payload
  pt_idx_t              seg1_r, seg_nxt;
  stroke_t              off1_r;
  logic                 oor1_r, oor_nxt;
  logic [DUTY_W:0]      ap1_r, bp1_r;
  logic signed [DUTY_W+1:0] am1_r, bm1_r;

  // stage 2 payload
  scaled_t w1lo2_r, w1hi2_r, w2lo2_r, w2hi2_r;
  scaled_t ap2_r, am2_r, bp2_r, bm2_r;
  logic    oor2_r;

  // stage 3 (output) payload
  logic straight_r, swapped_r, oor3_r;

  assign en3      = !v3_r || !out_stall;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_stall = !en1;
  assign cfg_ready = 1'b1;

  // Segment search: first segment whose closed interval holds the stroke.
  always_comb begin
    seg_nxt = '0;
    oor_nxt = 1'b1;
    for (int i = TABLE_POINTS - 2; i >= 0; i--) begin
      if (in_stroke_value >= POS_TAB[i] && in_stroke_value <= POS_TAB[i+1] &&
          POS_TAB[i+1] > POS_TAB[i]) begin
        seg_nxt = PT_W'(i);
        oor_nxt = 1'b0;
      end
    end
  end

  // Stage 2 arithmetic.
  pt_idx_t                  seg_hi;
  stroke_t                  den;
  logic signed [STROKE_W:0] off_s, den_s;
  logic signed [DUTY_W:0]   d1lo, d1hi, d2lo, d2hi;
  logic signed [DUTY_W:0]   b1lo, b1hi, b2lo, b2hi;
  scaled_t                  w1lo_nxt, w1hi_nxt, w2lo_nxt, w2hi_nxt;
  scaled_t                  ap_nxt, am_nxt, bp_nxt, bm_nxt;

  always_comb begin
    seg_hi = seg1_r + pt_idx_t'(1);
    den    = POS_TAB[seg_hi] - POS_TAB[seg1_r];
    off_s  = $signed({1'b0, off1_r});
    den_s  = $signed({1'b0, den});
    b1lo   = $signed({1'b0, C1_LO_TAB[seg1_r]});
    b1hi   = $signed({1'b0, C1_HI_TAB[seg1_r]});
    b2lo   = $signed({1'b0, C2_LO_TAB[seg1_r]});
    b2hi   = $signed({1'b0, C2_HI_TAB[seg1_r]});
    d1lo   = $signed({1'b0, C1_LO_TAB[seg_hi]}) - b1lo;
    d1hi   = $signed({1'b0, C1_HI_TAB[seg_hi]}) - b1hi;
    d2lo   = $signed({1'b0, C2_LO_TAB[seg_hi]}) - b2lo;
    d2hi   = $signed({1'b0, C2_HI_TAB[seg_hi]}) - b2hi;
    // base limit times length is a product of table constants per segment
    w1lo_nxt = scaled_t'(b1lo) * scaled_t'(den_s) + scaled_t'(off_s) * scaled_t'(d1lo);
    w1hi_nxt = scaled_t'(b1hi) * scaled_t'(den_s) + scaled_t'(off_s) * scaled_t'(d1hi);
    w2lo_nxt = scaled_t'(b2lo) * scaled_t'(den_s) + scaled_t'(off_s) * scaled_t'(d2lo);
    w2hi_nxt = scaled_t'(b2hi) * scaled_t'(den_s) + scaled_t'(off_s) * scaled_t'(d2hi);
    ap_nxt   = scaled_t'($signed({1'b0, ap1_r})) * scaled_t'(den_s);
    am_nxt   = scaled_t'(am1_r) * scaled_t'(den_s);
    bp_nxt   = scaled_t'($signed({1'b0, bp1_r})) * scaled_t'(den_s);
    bm_nxt   = scaled_t'(bm1_r) * scaled_t'(den_s);
  end

  // Stage 3 window compares.
  logic a_in1, a_in2, b_in1, b_in2;
  logic straight_nxt, swapped_nxt;

  always_comb begin
    a_in1 = (ap2_r >= w1lo2_r) && (am2_r <= w1hi2_r);
    a_in2 = (ap2_r >= w2lo2_r) && (am2_r <= w2hi2_r);
    b_in1 = (bp2_r >= w1lo2_r) && (bm2_r <= w1hi2_r);
    b_in2 = (bp2_r >= w2lo2_r) && (bm2_r <= w2hi2_r);
    straight_nxt = !oor2_r && a_in1 && b_in2;
    swapped_nxt  = !oor2_r && a_in2 && b_in1;
  end

  // Control: valid bits and tolerance register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      tol_r <= TOL_RESET;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (cfg_valid && cfg_ready) tol_r <= cfg_tolerance;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      seg1_r <= seg_nxt;
      oor1_r <= oor_nxt;
      off1_r <= in_stroke_value - POS_TAB[seg_nxt];
      ap1_r  <= {1'b0, in_duty_a} + (DUTY_W+1)'(tol_r);
      bp1_r  <= {1'b0, in_duty_b} + (DUTY_W+1)'(tol_r);
      am1_r  <= $signed({2'b00, in_duty_a}) - $signed((DUTY_W+2)'(tol_r));
      bm1_r  <= $signed({2'b00, in_duty_b}) - $signed((DUTY_W+2)'(tol_r));
    end
    if (en2 && v1_r) begin
      oor2_r  <= oor1_r;
      w1lo2_r <= w1lo_nxt;
      w1hi2_r <= w1hi_nxt;
      w2lo2_r <= w2lo_nxt;
      w2hi2_r <= w2hi_nxt;
      ap2_r   <= ap_nxt;
      am2_r   <= am_nxt;
      bp2_r   <= bp_nxt;
      bm2_r   <= bm_nxt;
    end
    if (en3 && v2_r) begin
      oor3_r     <= oor2_r;
      straight_r <= straight_nxt;
      swapped_r  <= swapped_nxt;
    end
  end

  assign out_valid          = v3_r;
  assign out_straight_match = straight_r;
  assign out_swapped_match  = swapped_r;
  assign out_passed         = straight_r || swapped_r;
  assign out_out_of_range   = oor3_r;

endmodule

`default_nettype wire

// ===== hdl/idwc_chk.sv =====
// Port-level checker for the duty window check unit, with its bind.
`timescale 1ns / 1ps
`default_nettype none

`include "interpolated_duty_window_check_unit_macros.svh"

module idwc_chk (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic out_passed,
  input wire logic out_straight_match,
  input wire logic out_swapped_match,
  input wire logic out_out_of_range
);

  `IDWC_ASSERT_NOW(a_pass_is_or, clk, rst_n, out_valid, out_passed == (out_straight_match || out_swapped_match), "passed is not the OR of the matches")

  `IDWC_ASSERT_NOW(a_oor_no_match, clk, rst_n, out_valid && out_out_of_range, !out_passed && !out_straight_match && !out_swapped_match, "match reported for out-of-range stroke")

  `IDWC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_passed) && $stable(out_straight_match) && $stable(out_swapped_match) && $stable(out_out_of_range), "stalled result changed")

  `IDWC_ASSERT_NEXT(a_latency, clk, rst_n, in_valid && !in_stall ##1 !out_stall ##1 !out_stall, out_valid, "result missing after pipeline latency")

endmodule

bind interpolated_duty_window_check_unit idwc_chk u_idwc_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_passed         (out_passed),
  .out_straight_match (out_straight_match),
  .out_swapped_match  (out_swapped_match),
  .out_out_of_range   (out_out_of_range)
);

`default_nettype wire
